>>> hw/rtl/ultrasonic_ranging_controller_defines.svh
// ---------------------------------------------------------------------------
// ultrasonic ranging controller assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGING_CONTROLLER_DEFINES_SVH
`define ULTRASONIC_RANGING_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define URC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define URC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define URC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)

`define URC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hw/rtl/urc_pkg.sv
// ---------------------------------------------------------------------------
// ultrasonic ranging controller package
// widths, phase codes, status codes and register map
// ---------------------------------------------------------------------------
package urc_pkg;

    localparam int TIME_BITS = 16;
    localparam int DIST_BITS = 10;

    localparam int CFG_TIME_W = 16;
    localparam int CFG_PER_W  = 8;
    localparam int CFG_DIST_W = 10;
    localparam int DIST_OUT_W = 10;
    localparam int STATUS_W   = 2;

    localparam int TCMP_W = ((TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W) + 1;
    localparam int DCMP_W = (DIST_BITS > CFG_DIST_W) ? DIST_BITS : CFG_DIST_W;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [2:0] REG_ENABLE    = 3'd0;
    localparam logic [2:0] REG_TRIG_W    = 3'd1;
    localparam logic [2:0] REG_TIMEOUT   = 3'd2;
    localparam logic [2:0] REG_US_PER_CM = 3'd3;
    localparam logic [2:0] REG_MAX_DIST  = 3'd4;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;
    localparam logic [1:0] PH_TIME = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

    localparam logic [CFG_TIME_W-1:0] RST_TRIG_W    = 16'd1000;
    localparam logic [CFG_TIME_W-1:0] RST_TIMEOUT   = 16'd40000;
    localparam logic [CFG_PER_W-1:0]  RST_US_PER_CM = 8'd58;
    localparam logic [CFG_DIST_W-1:0] RST_MAX_DIST  = 10'd99;

endpackage

>>> hw/rtl/ultrasonic_ranging_controller.sv
// ---------------------------------------------------------------------------
// ultrasonic ranging controller
// Each request is one microsecond tick carrying the measure request and the
// sampled echo level; every request yields exactly one result in the cycle after
// it is taken, and a new request is taken every cycle while the result
// register is empty or being drained. The trigger is held for
// trigger_width_us ticks, the echo rise is awaited for echo_timeout_us ticks,
// and the echo high time is counted in units of us_per_cm ticks into whole centimetres
// (saturating). Results report ok with the distance, echo timeout, or out of
// range. State advances only while enable is set. Write configuration only
// while no result is pending.
// ---------------------------------------------------------------------------
`include "ultrasonic_ranging_controller_defines.svh"

module ultrasonic_ranging_controller
    import urc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  measure_request,
    input  logic                  echo_level,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  trigger_level,
    output logic                  done_res,
    output logic [STATUS_W-1:0]   status,
    output logic [DIST_OUT_W-1:0] distance_cm,
    output logic                  busy_res
);

    // configuration
    logic                  enable_reg;
    logic [CFG_TIME_W-1:0] trig_width_reg;
    logic [CFG_TIME_W-1:0] timeout_reg;
    logic [CFG_PER_W-1:0]  per_cm_reg;
    logic [CFG_DIST_W-1:0] max_dist_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            trig_width_reg <= RST_TRIG_W;
            timeout_reg    <= RST_TIMEOUT;
            per_cm_reg     <= RST_US_PER_CM;
            max_dist_reg   <= RST_MAX_DIST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_ENABLE:    enable_reg     <= pwdata[0];
                REG_TRIG_W:    trig_width_reg <= pwdata[CFG_TIME_W-1:0];
                REG_TIMEOUT:   timeout_reg    <= pwdata[CFG_TIME_W-1:0];
                REG_US_PER_CM: per_cm_reg     <= pwdata[CFG_PER_W-1:0];
                REG_MAX_DIST:  max_dist_reg   <= pwdata[CFG_DIST_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (cfg_idx)
            REG_ENABLE:    prdata = PDATA_W'(enable_reg);
            REG_TRIG_W:    prdata = PDATA_W'(trig_width_reg);
            REG_TIMEOUT:   prdata = PDATA_W'(timeout_reg);
            REG_US_PER_CM: prdata = PDATA_W'(per_cm_reg);
            REG_MAX_DIST:  prdata = PDATA_W'(max_dist_reg);
            default:       prdata = '0;
        endcase
    end

    // measurement state
    logic [1:0]           phase_reg,     phase_next;
    logic [TIME_BITS-1:0] tick_reg,      tick_next;
    logic [CFG_PER_W-1:0] sub_cm_reg,    sub_cm_next;
    logic [DIST_BITS-1:0] cm_reg,        cm_next;
    logic                 echo_prev_reg;
    logic                 rise_seen_reg, rise_seen_next;

    // result register
    logic                  out_valid_reg;
    logic                  trig_out_reg;
    logic                  done_out_reg;
    logic [STATUS_W-1:0]   status_out_reg;
    logic [DIST_OUT_W-1:0] dist_out_reg;
    logic                  busy_out_reg;

    logic                  done_next;
    logic [STATUS_W-1:0]   status_next;
    logic [DIST_OUT_W-1:0] dist_next;

    logic                  accept;
    logic                  rise;
    logic [TCMP_W-1:0]     tick_inc;
    logic                  trig_end;
    logic                  wait_end;
    logic [CFG_PER_W-1:0]  per;
    logic [CFG_PER_W-1:0]  sub_base;
    logic [DIST_BITS-1:0]  cm_base;
    logic [CFG_PER_W:0]    sub_inc;
    logic                  sub_wrap;
    logic [CFG_PER_W-1:0]  sub_cnt;
    logic [DIST_BITS-1:0]  cm_cnt;
    logic                  over_range;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign rise     = echo_level & ~echo_prev_reg;

    assign tick_inc = TCMP_W'(tick_reg) + TCMP_W'(1);
    assign trig_end = tick_inc >= TCMP_W'(trig_width_reg);
    assign wait_end = tick_inc >= TCMP_W'(timeout_reg);

    // one echo tick into the centimetre counter
    assign per      = (per_cm_reg == '0) ? CFG_PER_W'(1) : per_cm_reg;
    assign sub_base = (phase_reg == PH_TIME) ? sub_cm_reg : '0;
    assign cm_base  = (phase_reg == PH_TIME) ? cm_reg : '0;
    assign sub_inc  = {1'b0, sub_base} + (CFG_PER_W+1)'(1);
    assign sub_wrap = sub_inc >= {1'b0, per};
    assign sub_cnt  = sub_wrap ? '0 : sub_inc[CFG_PER_W-1:0];
    assign cm_cnt   = (sub_wrap && cm_base != DIST_MAX) ? cm_base + DIST_BITS'(1) : cm_base;

    assign over_range = DCMP_W'(cm_reg) > DCMP_W'(max_dist_reg);

    always_comb
    begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        sub_cm_next    = sub_cm_reg;
        cm_next        = cm_reg;
        rise_seen_next = rise_seen_reg;
        done_next      = 1'b0;
        status_next    = ST_OK;
        dist_next      = '0;
        if (enable_reg)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    rise_seen_next = 1'b0;
                    if (measure_request)
                    begin
                        phase_next = PH_TRIG;
                        tick_next  = '0;
                    end
                end
                PH_TRIG:
                begin
                    if (rise)
                    begin
                        rise_seen_next = 1'b1;
                    end
                    if (trig_end)
                    begin
                        phase_next = PH_WAIT;
                        tick_next  = '0;
                    end
                    else if (tick_reg != TIME_MAX)
                    begin
                        tick_next = tick_inc[TIME_BITS-1:0];
                    end
                end
                PH_WAIT:
                begin
                    // rise wins over a coincident timeout
                    if (rise || rise_seen_reg)
                    begin
                        phase_next     = PH_TIME;
                        rise_seen_next = 1'b0;
                        tick_next      = '0;
                        sub_cm_next    = sub_cnt;
                        cm_next        = cm_cnt;
                    end
                    else if (wait_end)
                    begin
                        phase_next  = PH_IDLE;
                        tick_next   = '0;
                        done_next   = 1'b1;
                        status_next = ST_TIMEOUT;
                    end
                    else if (tick_reg != TIME_MAX)
                    begin
                        tick_next = tick_inc[TIME_BITS-1:0];
                    end
                end
                PH_TIME:
                begin
                    if (!echo_level)
                    begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                        if (over_range)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            dist_next = DIST_OUT_W'(cm_reg);
                        end
                    end
                    else
                    begin
                        sub_cm_next = sub_cnt;
                        cm_next     = cm_cnt;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            sub_cm_reg    <= '0;
            cm_reg        <= '0;
            echo_prev_reg <= 1'b0;
            rise_seen_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            sub_cm_reg    <= sub_cm_next;
            cm_reg        <= cm_next;
            echo_prev_reg <= echo_level;
            rise_seen_reg <= rise_seen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            trig_out_reg   <= (phase_next == PH_TRIG);
            done_out_reg   <= done_next;
            status_out_reg <= status_next;
            dist_out_reg   <= dist_next;
            busy_out_reg   <= (phase_next != PH_IDLE);
        end
    end

    assign out_valid     = out_valid_reg;
    assign trigger_level = trig_out_reg;
    assign done_res      = done_out_reg;
    assign status        = status_out_reg;
    assign distance_cm   = dist_out_reg;
    assign busy_res      = busy_out_reg;

    `URC_ASSERT_NOW(a_err_no_dist, clk, rst_n,
        out_valid_reg && status_out_reg != ST_OK, dist_out_reg == '0, "distance on error")
    `URC_ASSERT_NOW(a_done_idle, clk, rst_n,
        out_valid_reg && done_out_reg, !busy_out_reg, "done while still busy")
    `URC_ASSERT_NOW(a_trig_busy, clk, rst_n,
        out_valid_reg && trig_out_reg, busy_out_reg, "trigger outside measurement")
    `URC_ASSERT_NOW(a_time_no_latch, clk, rst_n,
        phase_reg == PH_TIME, !rise_seen_reg, "stale early rise in echo timing")
    `URC_ASSERT_NEXT(a_idle_hold, clk, rst_n,
        accept && phase_reg == PH_IDLE && !measure_request, phase_reg == PH_IDLE,
        "left idle without request")

endmodule
